// ===== rtl/core/packed_array_insert_delete_macros.svh =====
// Assertion macros shared by the packed array insert/delete block.
`ifndef PACKED_ARRAY_INSERT_DELETE_MACROS_SVH
`define PACKED_ARRAY_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pad_pkg.sv =====
// Package: types, codes and constants of the packed array insert/delete block.
package pad_pkg;

	localparam int DATA_W          = 32;
	localparam int POS_W           = 6;
	localparam int CNT_W           = 7;
	localparam int KIND_W          = 3;
	localparam int STAT_W          = 2;
	localparam int MAX_ENTRIES_DEF = 64;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EDIT   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_GET    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INDEX = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         element_count;
	} rsp_t;

endpackage

// ===== rtl/core/pad_mem.sv =====
// Element store: one write port, one read port, registered read data.
module pad_mem #(
	parameter int MAX_ENTRIES = pad_pkg::MAX_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(MAX_ENTRIES)-1:0]     waddr,
	input  logic [pad_pkg::DATA_W-1:0]         wdata,
	input  logic [$clog2(MAX_ENTRIES)-1:0]     raddr,
	output logic [pad_pkg::DATA_W-1:0]         rdata
);
	import pad_pkg::*;

	logic [DATA_W-1:0] entries_q [MAX_ENTRIES];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			entries_q[waddr] <= wdata;
		end
		rdata_q <= entries_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pad_ctrl.sv =====
// Sequencer: decodes requests, runs the shift sweeps and builds results.
module pad_ctrl #(
	parameter int MAX_ENTRIES = pad_pkg::MAX_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  pad_pkg::req_t                      req,
	input  logic [pad_pkg::CNT_W-1:0]          cap,
	output logic                               done,
	output pad_pkg::rsp_t                      rsp,
	output logic                               mem_we,
	output logic [$clog2(MAX_ENTRIES)-1:0]     mem_waddr,
	output logic [pad_pkg::DATA_W-1:0]         mem_wdata,
	output logic [$clog2(MAX_ENTRIES)-1:0]     mem_raddr,
	input  logic [pad_pkg::DATA_W-1:0]         mem_rdata
);
	import pad_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int MW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = (MW > CNT_W) ? MW : CNT_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_LAST  = 4'b0100,
		S_GET   = 4'b1000
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   wa_q, wa_d;
	logic [CNT_W-1:0]   last_q, last_d;
	logic               up_q, up_d;
	logic [DATA_W-1:0]  val_q;
	logic [CNT_W-1:0]   pos_q;
	logic [DATA_W-1:0]  rd_q, rd_d;
	logic [STAT_W-1:0]  st_q, st_d;
	logic               done_q, done_d;

	logic [CNT_W-1:0]   pos7;
	logic [CNT_W-1:0]   cap_lo;
	logic [XW-1:0]      count_x;
	logic               full;
	logic               accept;

	function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] idx);
		logic [AW+CNT_W-1:0] w;
		w = {{AW{1'b0}}, idx};
		return w[AW-1:0];
	endfunction

	assign pos7    = {1'b0, req.position};
	assign cap_lo  = (cap == '0) ? 7'd1 : cap;
	assign count_x = XW'(count_q);
	assign full    = (count_q >= cap_lo) || (count_x >= XW'(MAX_ENTRIES));
	assign accept  = start && (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		wa_d      = wa_q;
		last_d    = last_q;
		up_d      = up_q;
		rd_d      = '0;
		st_d      = STAT_OK;
		done_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = req.value;
		mem_raddr = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind) inside
						KIND_APPEND, KIND_INSERT: begin
							if (full) begin
								st_d   = STAT_FULL;
								done_d = 1'b1;
							end else if (req.kind == KIND_APPEND || pos7 >= count_q) begin
								mem_we    = 1'b1;
								mem_waddr = to_addr(count_q);
								count_d   = count_q + 7'd1;
								done_d    = 1'b1;
							end else begin
								// open a gap: move the tail up, top entry first
								mem_raddr = to_addr(count_q - 7'd1);
								wa_d      = count_q;
								last_d    = pos7 + 7'd1;
								up_d      = 1'b1;
								state_d   = S_SHIFT;
							end
						end
						KIND_EDIT: begin
							done_d = 1'b1;
							if (count_q == '0) begin
								mem_we  = 1'b1;
								count_d = 7'd1;
							end else if (pos7 >= count_q) begin
								st_d = STAT_INDEX;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = to_addr(pos7);
							end
						end
						KIND_DELETE: begin
							if (count_q == '0) begin
								st_d   = STAT_EMPTY;
								done_d = 1'b1;
							end else if (pos7 >= count_q) begin
								st_d   = STAT_INDEX;
								done_d = 1'b1;
							end else if (pos7 == count_q - 7'd1) begin
								count_d = count_q - 7'd1;
								done_d  = 1'b1;
							end else begin
								// close the gap: move the tail down, lowest entry first
								mem_raddr = to_addr(pos7 + 7'd1);
								wa_d      = pos7;
								last_d    = count_q - 7'd2;
								up_d      = 1'b0;
								state_d   = S_SHIFT;
							end
						end
						KIND_GET: begin
							if (count_q == '0) begin
								st_d   = STAT_EMPTY;
								done_d = 1'b1;
							end else if (pos7 >= count_q) begin
								st_d   = STAT_INDEX;
								done_d = 1'b1;
							end else begin
								mem_raddr = to_addr(pos7);
								state_d   = S_GET;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = to_addr(wa_q);
				mem_wdata = mem_rdata;
				if (wa_q == last_q) begin
					if (up_q) begin
						state_d = S_LAST;
					end else begin
						count_d = count_q - 7'd1;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					mem_raddr = up_q ? to_addr(wa_q - 7'd2) : to_addr(wa_q + 7'd2);
					wa_d      = up_q ? (wa_q - 7'd1) : (wa_q + 7'd1);
				end
			end
			S_LAST: begin
				mem_we    = 1'b1;
				mem_waddr = to_addr(pos_q);
				mem_wdata = val_q;
				count_d   = count_q + 7'd1;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end
			S_GET: begin
				rd_d    = mem_rdata;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		wa_q   <= wa_d;
		last_q <= last_d;
		up_q   <= up_d;
		rd_q   <= rd_d;
		st_q   <= st_d;
		if (accept) begin
			val_q <= req.value;
			pos_q <= pos7;
		end
	end

	assign busy              = (state_q != S_IDLE);
	assign done              = done_q;
	assign rsp.read_data     = rd_q;
	assign rsp.status        = st_q;
	assign rsp.element_count = count_q;

endmodule

// ===== rtl/core/packed_array_insert_delete.sv =====
// Sequence: append, edit, failed requests and a delete of the last entry finish
//   from idle; get adds a read state; delete sweeps the moved entries, and insert
//   sweeps them, then writes the new value. Throughput: one request at a time;
//   a sweep moves one entry per cycle, set by the single write port of the store.
// Reset: arst_n clears the count to zero and the capacity to 64; stored elements
//   are undefined until written. Results are a one-cycle strobe, never stalled.
`include "packed_array_insert_delete_macros.svh"

// Top level: packed array with insert/delete by shifting.
module packed_array_insert_delete #(
	parameter int MAX_ENTRIES = pad_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request beat: taken when start is high and busy is low
	input  logic                        start,
	output logic                        busy,
	input  pad_pkg::req_t               req,
	// result beat: valid for exactly the cycle done is high
	output logic                        done,
	output pad_pkg::rsp_t               rsp,
	// capacity register write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pad_pkg::CNT_W-1:0]   cfg_data
);
	import pad_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);

	logic [CNT_W-1:0]  cap_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	// Take a capacity beat only while the sequencer rests and no request is
	// offered, so a write never lands beside a request in the same cycle.
	assign cfg_ready = !busy && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Sequencer: decodes the request, walks the shift sweep one entry per
	// cycle (read entry, write it one slot over on the next cycle) and holds
	// the element count.
	pad_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cap       (cap_q),
		.done      (done),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Element store: during a sweep, each read that feeds a later move runs two
	// slots ahead of the write made in the same cycle.
	pad_mem #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Results are only produced once the sequencer is back at rest.
	`PAD_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result while busy")
	// An empty status always reports an empty array.
	`PAD_ASSERT_IMPLY(a_empty_cnt, clk, arst_n, done && rsp.status == STAT_EMPTY,
		rsp.element_count == '0, "empty status with nonzero count")
	// A full status can never come from an empty array.
	`PAD_ASSERT_IMPLY(a_full_cnt, clk, arst_n, done && rsp.status == STAT_FULL,
		rsp.element_count != '0, "full status with zero count")
	// Read data is nonzero only for a successful get.
	`PAD_ASSERT_IMPLY(a_rd_ok, clk, arst_n, done && rsp.read_data != '0,
		rsp.status == STAT_OK, "read data on failed request")

endmodule

// ===== test/pad_tb_pkg.sv =====
// Package: array mirror that predicts and checks results of the packed array block.
`timescale 1ns / 1ps

package pad_tb_pkg;

	import pad_pkg::*;

	class array_mirror;
		logic signed [DATA_W-1:0] slots [MAX_ENTRIES_DEF];
		int unsigned              fill;
		logic [CNT_W-1:0]         cap_reg;
		rsp_t                     owed [$];
		int unsigned              errors;

		function new();
			fill = 0;
			cap_reg = CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] v);
			cap_reg = v;
		endfunction

		// Clamp the register to 1 .. MAX_ENTRIES.
		function int unsigned room();
			if (cap_reg == 0)
				return 1;
			if (cap_reg > MAX_ENTRIES_DEF)
				return MAX_ENTRIES_DEF;
			return cap_reg;
		endfunction

		function int unsigned held();
			return fill;
		endfunction

		function int unsigned waiting();
			return owed.size();
		endfunction

		// Apply one accepted request to the mirror and queue the result it owes.
		function void take_request(req_t r);
			rsp_t        e;
			int unsigned i;
			int unsigned p;
			e = '0;
			e.status = STAT_OK;
			p = r.position;
			case (r.kind)
				KIND_APPEND, KIND_INSERT: begin
					if (fill >= room() || fill >= MAX_ENTRIES_DEF) begin
						e.status = STAT_FULL;
					end else if (r.kind == KIND_APPEND || p >= fill) begin
						slots[fill] = r.value;
						fill++;
					end else begin
						for (i = fill; i > p; i--)
							slots[i] = slots[i - 1];
						slots[p] = r.value;
						fill++;
					end
				end
				KIND_EDIT: begin
					if (fill == 0) begin
						slots[0] = r.value;
						fill = 1;
					end else if (p >= fill) begin
						e.status = STAT_INDEX;
					end else begin
						slots[p] = r.value;
					end
				end
				KIND_DELETE: begin
					if (fill == 0) begin
						e.status = STAT_EMPTY;
					end else if (p >= fill) begin
						e.status = STAT_INDEX;
					end else begin
						for (i = p; i + 1 < fill; i++)
							slots[i] = slots[i + 1];
						fill--;
					end
				end
				KIND_GET: begin
					if (fill == 0)
						e.status = STAT_EMPTY;
					else if (p >= fill)
						e.status = STAT_INDEX;
					else
						e.read_data = slots[p];
				end
				default: ;
			endcase
			e.element_count = CNT_W'(fill);
			owed.push_back(e);
		endfunction

		// Compare one result beat with the oldest owed result.
		function void match_result(rsp_t got);
			rsp_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, got %h", $time, got);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.read_data !== e.read_data) begin
				$display("%0t: read_data expected %h got %h", $time, e.read_data, got.read_data);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.element_count !== e.element_count) begin
				$display("%0t: element_count expected %0d got %0d", $time,
					e.element_count, got.element_count);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== test/packed_array_insert_delete_test.sv =====
// Testbench top: random and directed requests against the packed array block.
`timescale 1ns / 1ps

module packed_array_insert_delete_test;

	import pad_pkg::*;
	import pad_tb_pkg::*;

	// A stretch this long with no beat at all means the block hung.
	// The slowest request shifts the whole array.
	localparam int STALL_LIMIT = 2000;
	// Hold-off after the last result: worst-case request latency plus margin.
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 145;
	// Phase that runs without any sender gaps.
	localparam int QUIET_PHASE = 4;
	// Phase whose capacity is drawn at random.
	localparam int RANDOM_CAP_PHASE = 7;

	// Capacity per phase: clamp extremes (0, 127, 65), tiny sizes, capacity
	// under the held count (3 after a fill to 64), and a final drain.
	localparam int PHASE_CAP  [PHASES] = '{127,  3,  1,  0, 64, 17,  2, 64, 65, 64};
	localparam int PHASE_GROW [PHASES] = '{ 70, 30, 40, 40, 45, 50, 40, 50, 60, 25};
	localparam int PHASE_DROP [PHASES] = '{ 10, 45, 30, 30, 40, 30, 40, 35, 20, 60};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	array_mirror mirror;
	int unsigned stall_cycles = 0;

	packed_array_insert_delete DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample every beat in one process at the rising edge, so a request and
	// a result landing on the same edge are always seen in that order.
	always @(posedge clk) begin : beat_monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				mirror.set_capacity(cfg_data);
				moved = 1'b1;
			end
			if (start && !busy) begin
				mirror.take_request(req);
				moved = 1'b1;
			end
			if (done) begin
				mirror.match_result(rsp);
				moved = 1'b1;
			end
		end
		if (moved)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic req_t cmd(logic [KIND_W-1:0] k, logic [DATA_W-1:0] v,
		logic [POS_W-1:0] p);
		req_t r;
		r.kind = k;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	// Roughly one beat in ten is preceded by a short gap.
	function automatic int unsigned pick_gap(bit idle_on);
		if (idle_on && $urandom_range(0, 99) < 10)
			return $urandom_range(1, 4);
		return 0;
	endfunction

	// Draw a request; aim positions mostly inside the held range.
	function automatic req_t draw_request(int unsigned grow_pct, int unsigned drop_pct);
		req_t        r;
		int unsigned roll;
		int unsigned n;
		n = mirror.held();
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r.kind = KIND_GET + KIND_W'($urandom_range(1, 3));
		else if (roll < 3 + grow_pct)
			r.kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
		else if (roll < 3 + grow_pct + drop_pct)
			r.kind = KIND_DELETE;
		else
			r.kind = $urandom_range(0, 1) ? KIND_GET : KIND_EDIT;
		case ($urandom_range(0, 9))
			0: r.value = 32'h7fff_ffff;
			1: r.value = 32'h8000_0000;
			2: r.value = '1;
			3: r.value = '0;
			default: r.value = $urandom;
		endcase
		if (n > 0 && $urandom_range(0, 9) < 7)
			r.position = POS_W'($urandom_range(0, n - 1));
		else
			r.position = POS_W'($urandom_range(0, 63));
		return r;
	endfunction

	// Present a request after an optional gap; hold it until the block takes it.
	task automatic send(input req_t item, input int unsigned gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and wait until every owed result is back and the block is idle.
	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (mirror.waiting() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		req_t        opening [$];
		req_t        item;
		int unsigned taken;
		logic [CNT_W-1:0] cap;

		mirror = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Opening run at the reset capacity: empty-array reads and deletes,
		// edit on empty, edit, delete and get past the end, insert past the
		// end, insert at the front and middle, data extremes, spare kinds,
		// drain to empty, then insert on an empty array.
		opening = '{
			cmd(KIND_GET,    32'h0000_0000, 6'd0),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd0),
			cmd(KIND_EDIT,   32'h1234_5678, 6'd63),
			cmd(KIND_EDIT,   32'hdead_beef, 6'd63),
			cmd(KIND_INSERT, 32'h7fff_ffff, 6'd63),
			cmd(KIND_APPEND, 32'h8000_0000, 6'd0),
			cmd(KIND_INSERT, 32'hffff_ffff, 6'd0),
			cmd(KIND_INSERT, 32'h0000_0000, 6'd2),
			cmd(KIND_GET,    32'h0000_0000, 6'd2),
			cmd(KIND_GET,    32'h0000_0000, 6'd4),
			cmd(KIND_GET,    32'h0000_0000, 6'd5),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd63),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd0),
			cmd(KIND_GET + 3'd1, 32'hffff_ffff, 6'd63),
			cmd(KIND_GET + 3'd2, 32'hffff_ffff, 6'd63),
			cmd(KIND_GET + 3'd3, 32'hffff_ffff, 6'd63),
			cmd(KIND_EDIT,   32'h5555_5555, 6'd1),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd3),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd1),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd0),
			cmd(KIND_DELETE, 32'h0000_0000, 6'd0),
			cmd(KIND_INSERT, 32'h0000_ffff, 6'd40),
			cmd(KIND_GET,    32'h0000_0000, 6'd0),
			cmd(KIND_GET,    32'h0000_0000, 6'd1)
		};
		foreach (opening[i])
			send(opening[i], pick_gap(1'b1));

		// Capacity of one with one element held: append and insert report full.
		quiesce();
		write_capacity(CNT_W'(1));
		send(cmd(KIND_APPEND, 32'haaaa_aaaa, 6'd0), 0);
		send(cmd(KIND_INSERT, 32'h5555_5555, 6'd0), 0);

		// Random phases; each begins with the block drained and idle.
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			if (p == RANDOM_CAP_PHASE)
				cap = CNT_W'($urandom_range(0, 127));
			else
				cap = CNT_W'(PHASE_CAP[p]);
			write_capacity(cap);
			taken = 0;
			while (taken < PHASE_ITEMS) begin
				item = draw_request(PHASE_GROW[p], PHASE_DROP[p]);
				if (item.kind <= KIND_GET)
					taken++;
				send(item, pick_gap(p != QUIET_PHASE));
				// Now and then hold the sender until the block runs dry.
				if (p != QUIET_PHASE && $urandom_range(0, 99) == 0)
					quiesce();
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.waiting() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pad_pkg.sv
rtl/core/pad_mem.sv
rtl/core/pad_ctrl.sv
rtl/core/packed_array_insert_delete.sv
test/pad_tb_pkg.sv
test/packed_array_insert_delete_test.sv
